/* rtl/core/fdtsbp_pkg.sv */
`default_nettype none

package fdtsbp_pkg;

  localparam int unsigned DefMaxDepth = 16;

  localparam int unsigned DepthW = 5;
  localparam int unsigned EventW = 3;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
  localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
  localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
  localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
  localparam logic [31:0] TOK_END        = 32'h0000_0009;

  localparam logic [EventW-1:0] EV_CHAR   = 3'd0;
  localparam logic [EventW-1:0] EV_OPEN   = 3'd1;
  localparam logic [EventW-1:0] EV_CLOSE  = 3'd2;
  localparam logic [EventW-1:0] EV_PROP   = 3'd3;
  localparam logic [EventW-1:0] EV_FINISH = 3'd4;
  localparam logic [EventW-1:0] EV_ERROR  = 3'd5;

  typedef enum logic [3:0] {
    MODE_FIRST     = 4'd0,
    MODE_NAME      = 4'd1,
    MODE_PAD       = 4'd2,
    MODE_TOKEN     = 4'd3,
    MODE_PROP_LEN  = 4'd4,
    MODE_PROP_OFF  = 4'd5,
    MODE_PAYLOAD   = 4'd6,
    MODE_END_TOKEN = 4'd7,
    MODE_DONE      = 4'd8,
    MODE_ERROR     = 4'd9
  } mode_e;

  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [DepthW-1:0] depth;
    logic [7:0]        name_char;
    logic [31:0]       prop_name_offset;
    logic [31:0]       prop_length;
  } res_item_t;

endpackage

`default_nettype wire

/* rtl/core/fdtsbp_if.sv */
`default_nettype none

interface fdtsbp_in_if;
  logic       valid;
  logic       ready;
  logic       first_byte;
  logic [7:0] data_byte;

  modport source (output valid, output first_byte, output data_byte, input ready);
  modport sink   (input valid, input first_byte, input data_byte, output ready);
endinterface

interface fdtsbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [4:0]  depth;
  logic [7:0]  name_char;
  logic [31:0] prop_name_offset;
  logic [31:0] prop_length;

  modport source (output valid, output event_res, output depth, output name_char,
                  output prop_name_offset, output prop_length, input ready);
  modport sink   (input valid, input event_res, input depth, input name_char,
                  input prop_name_offset, input prop_length, output ready);
endinterface

`default_nettype wire

/* rtl/core/fdtsbp_in_reg.sv */
`default_nettype none

module fdtsbp_in_reg
  import fdtsbp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire in_item_t item_i,
  output logic          ready_o,
  input  wire logic     adv_i,
  output logic          valid_o,
  output in_item_t      item_o
);

  logic     vld_q, vld_d;
  in_item_t item_q;

  // stage frees up whenever its item moves on in the same cycle
  assign ready_o = !vld_q || adv_i;
  assign vld_d   = (valid_i && ready_o) || (vld_q && !adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/core/fdtsbp_parse.sv */
`default_nettype none

module fdtsbp_parse
  import fdtsbp_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DefMaxDepth
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     adv_i,
  input  wire in_item_t item_i,
  output logic          res_valid_o,
  output res_item_t     res_o
);

  localparam int unsigned LvlW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ExtW = (LvlW > DepthW) ? LvlW : DepthW;

  mode_e            mode_q, mode_d, cur_mode;
  logic [1:0]       phase_q, phase_d, cur_phase;
  logic [31:0]      acc_q, acc_d, cur_acc, acc_sh;
  logic [31:0]      rem_q, rem_d, cur_rem, rem_dec;
  logic [31:0]      len_q, len_d, cur_len;
  logic [LvlW-1:0]  lvl_q, lvl_d, cur_lvl;
  logic [ExtW-1:0]  lvl_ext;
  logic             word_done;
  logic             ev_vld;
  logic [EventW-1:0] ev_code;
  logic [7:0]       ev_char;
  logic [31:0]      ev_off, ev_len;

  always_comb begin
    // a restart byte sees the reset state
    cur_mode  = item_i.first_byte ? MODE_FIRST : mode_q;
    cur_phase = item_i.first_byte ? 2'd0 : phase_q;
    cur_acc   = item_i.first_byte ? 32'd0 : acc_q;
    cur_rem   = item_i.first_byte ? 32'd0 : rem_q;
    cur_len   = item_i.first_byte ? 32'd0 : len_q;
    cur_lvl   = item_i.first_byte ? '0 : lvl_q;

    phase_d   = cur_phase + 2'd1;
    word_done = (phase_d == 2'd0);
    acc_sh    = {cur_acc[23:0], item_i.data_byte};
    rem_dec   = cur_rem - 32'd1;

    mode_d  = cur_mode;
    acc_d   = cur_acc;
    rem_d   = cur_rem;
    len_d   = cur_len;
    lvl_d   = cur_lvl;
    ev_vld  = 1'b0;
    ev_code = EV_ERROR;
    ev_char = 8'd0;
    ev_off  = 32'd0;
    ev_len  = 32'd0;

    case (cur_mode)
      MODE_FIRST, MODE_TOKEN, MODE_PROP_LEN, MODE_PROP_OFF, MODE_END_TOKEN: begin
        acc_d = acc_sh;
        if (word_done) begin
          case (cur_mode)
            MODE_FIRST: begin
              ev_vld = 1'b1;
              if (acc_sh == TOK_BEGIN_NODE) begin
                lvl_d   = LvlW'(1);
                mode_d  = MODE_NAME;
                ev_code = EV_OPEN;
              end else if (acc_sh == TOK_END) begin
                mode_d  = MODE_DONE;
                ev_code = EV_FINISH;
              end else begin
                mode_d  = MODE_ERROR;
                ev_code = EV_ERROR;
              end
            end
            MODE_END_TOKEN: begin
              ev_vld = 1'b1;
              if (acc_sh == TOK_END) begin
                mode_d  = MODE_DONE;
                ev_code = EV_FINISH;
              end else begin
                mode_d  = MODE_ERROR;
                ev_code = EV_ERROR;
              end
            end
            MODE_PROP_LEN: begin
              len_d  = acc_sh;
              mode_d = MODE_PROP_OFF;
            end
            MODE_PROP_OFF: begin
              ev_vld  = 1'b1;
              ev_code = EV_PROP;
              ev_off  = acc_sh;
              ev_len  = cur_len;
              rem_d   = cur_len;
              mode_d  = (cur_len == 32'd0) ? MODE_TOKEN : MODE_PAYLOAD;
            end
            default: begin
              if (acc_sh == TOK_BEGIN_NODE) begin
                ev_vld = 1'b1;
                if (cur_lvl >= LvlW'(MAX_DEPTH)) begin
                  mode_d  = MODE_ERROR;
                  ev_code = EV_ERROR;
                end else begin
                  lvl_d   = cur_lvl + LvlW'(1);
                  mode_d  = MODE_NAME;
                  ev_code = EV_OPEN;
                end
              end else if (acc_sh == TOK_END_NODE) begin
                ev_vld  = 1'b1;
                ev_code = EV_CLOSE;
                if (cur_lvl != '0) begin
                  lvl_d = cur_lvl - LvlW'(1);
                end
                // root closed: only the end token may follow
                if (cur_lvl <= LvlW'(1)) begin
                  mode_d = MODE_END_TOKEN;
                end
              end else if (acc_sh == TOK_PROP) begin
                mode_d = MODE_PROP_LEN;
              end else if (acc_sh != TOK_NOP) begin
                ev_vld  = 1'b1;
                ev_code = EV_ERROR;
                mode_d  = MODE_ERROR;
              end
            end
          endcase
        end
      end
      MODE_NAME: begin
        if (item_i.data_byte != 8'd0) begin
          ev_vld  = 1'b1;
          ev_code = EV_CHAR;
          ev_char = item_i.data_byte;
        end else begin
          mode_d = word_done ? MODE_TOKEN : MODE_PAD;
        end
      end
      MODE_PAD: begin
        if (word_done) begin
          mode_d = MODE_TOKEN;
        end
      end
      MODE_PAYLOAD: begin
        rem_d = rem_dec;
        if (rem_dec == 32'd0) begin
          mode_d = word_done ? MODE_TOKEN : MODE_PAD;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FIRST;
      phase_q <= 2'd0;
      acc_q   <= 32'd0;
      rem_q   <= 32'd0;
      len_q   <= 32'd0;
      lvl_q   <= '0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
      lvl_q   <= lvl_d;
    end
  end

  assign lvl_ext                = ExtW'(lvl_d);
  assign res_valid_o            = ev_vld;
  assign res_o.event_res        = ev_code;
  assign res_o.depth            = lvl_ext[DepthW-1:0];
  assign res_o.name_char        = ev_char;
  assign res_o.prop_name_offset = ev_off;
  assign res_o.prop_length      = ev_len;

endmodule

`default_nettype wire

/* rtl/core/fdtsbp_out_reg.sv */
`default_nettype none

module fdtsbp_out_reg
  import fdtsbp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wire res_item_t res_i,
  output logic           free_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output res_item_t      res_o
);

  logic      vld_q, vld_d;
  res_item_t res_q;

  assign free_o = !vld_q || ready_i;
  assign vld_d  = load_i || (vld_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

/* rtl/core/fdt_structure_block_parser.sv */
// channel | dir | payload                                         | accepted when
// in_i    | in  | first_byte, data_byte                           | valid && ready
// out_o   | out | event_res, depth, name_char, prop_name_offset,  | valid && ready
//         |     | prop_length                                     |
//
// one byte per cycle sustained unless a result stalls; from acceptance to
// result: input register, then parse state update feeding the result register.
// rst_ni clears the parse state and both valid flags at once.
// a stalled result holds the item in the input register; bytes that
// produce no result pass through without needing the result register.
`default_nettype none

module fdt_structure_block_parser
  import fdtsbp_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = DefMaxDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fdtsbp_in_if.sink    in_i,
  fdtsbp_out_if.source out_o
);

  in_item_t  in_item, stg_item;
  res_item_t res_new, res_out;
  logic      stg_vld, adv, res_vld, out_free, load;

  assign in_item.first_byte = in_i.first_byte;
  assign in_item.data_byte  = in_i.data_byte;

  // an item moves on unless it would produce a result into a full register
  assign adv  = stg_vld && (out_free || !res_vld);
  assign load = adv && res_vld;

  fdtsbp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_i.ready),
    .adv_i   (adv),
    .valid_o (stg_vld),
    .item_o  (stg_item)
  );

  fdtsbp_parse #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .item_i      (stg_item),
    .res_valid_o (res_vld),
    .res_o       (res_new)
  );

  fdtsbp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (res_new),
    .free_o  (out_free),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res_out)
  );

  assign out_o.event_res        = res_out.event_res;
  assign out_o.depth            = res_out.depth;
  assign out_o.name_char        = res_out.name_char;
  assign out_o.prop_name_offset = res_out.prop_name_offset;
  assign out_o.prop_length      = res_out.prop_length;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld && !adv |=> stg_vld)
    else $error("staged item lost while stalled");

  a_open_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.event_res == EV_OPEN |-> out_o.depth != '0 || MAX_DEPTH >= 32)
    else $error("node opened at level zero");

  a_len_only_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.event_res != EV_PROP |-> out_o.prop_length == 32'd0)
    else $error("property length on a non-property result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_o.valid || out_o.ready)
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_fdt_structure_block_parser.sv */
`timescale 1ns / 1ps

module tb_fdt_structure_block_parser;
  import fdtsbp_pkg::*;

  localparam int unsigned MaxDepth   = DefMaxDepth;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 45;

  logic clk_i;
  logic rst_ni;

  fdtsbp_in_if  in_if ();
  fdtsbp_out_if out_if ();

  fdt_structure_block_parser #(
    .MAX_DEPTH(MaxDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // tree walker state, mirrors the parser
  mode_e       tree_mode;
  logic [1:0]  tree_phase;
  logic [31:0] tree_word;
  logic [31:0] skip_left;
  logic [31:0] prop_len_held;
  logic [4:0]  tree_level;

  res_item_t   expected_events[$];
  logic [7:0]  block_bytes[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned sink_stall_left;
  int unsigned sink_hold_left;
  int unsigned cycle_count;
  int unsigned failures;
  int unsigned bytes_sent;
  int unsigned live_bytes;
  int unsigned blocks_sent;
  int unsigned events_checked;
  int unsigned event_seen[0:7];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_tree_state();
    tree_mode     = MODE_FIRST;
    tree_phase    = 2'd0;
    tree_word     = '0;
    skip_left     = '0;
    prop_len_held = '0;
    tree_level    = '0;
  endfunction

  // returns 1 when the byte is actually parsed rather than dropped
  function automatic bit parse_fdt_byte(input logic first, input logic [7:0] b);
    logic [1:0] nxt;
    logic       done;
    logic       emit;
    res_item_t  ev;
    bit         live;
    if (first) clear_tree_state();
    live = (tree_mode != MODE_DONE) && (tree_mode != MODE_ERROR);
    nxt  = tree_phase + 2'd1;
    done = (nxt == 2'd0);
    emit = 1'b0;
    ev   = '0;
    case (tree_mode)
      MODE_FIRST, MODE_TOKEN, MODE_PROP_LEN, MODE_PROP_OFF, MODE_END_TOKEN: begin
        tree_word = {tree_word[23:0], b};
        if (done) begin
          emit = 1'b1;
          case (tree_mode)
            MODE_FIRST: begin
              if (tree_word == TOK_BEGIN_NODE) begin
                tree_level   = 5'd1;
                tree_mode    = MODE_NAME;
                ev.event_res = EV_OPEN;
              end else if (tree_word == TOK_END) begin
                tree_mode    = MODE_DONE;
                ev.event_res = EV_FINISH;
              end else begin
                tree_mode    = MODE_ERROR;
                ev.event_res = EV_ERROR;
              end
            end
            MODE_END_TOKEN: begin
              if (tree_word == TOK_END) begin
                tree_mode    = MODE_DONE;
                ev.event_res = EV_FINISH;
              end else begin
                tree_mode    = MODE_ERROR;
                ev.event_res = EV_ERROR;
              end
            end
            MODE_PROP_LEN: begin
              prop_len_held = tree_word;
              tree_mode     = MODE_PROP_OFF;
              emit          = 1'b0;
            end
            MODE_PROP_OFF: begin
              ev.event_res        = EV_PROP;
              ev.prop_name_offset = tree_word;
              ev.prop_length      = prop_len_held;
              skip_left           = prop_len_held;
              if (prop_len_held == 0) tree_mode = MODE_TOKEN;
              else tree_mode = MODE_PAYLOAD;
            end
            default: begin
              if (tree_word == TOK_BEGIN_NODE) begin
                if (tree_level >= MaxDepth) begin
                  tree_mode    = MODE_ERROR;
                  ev.event_res = EV_ERROR;
                end else begin
                  tree_level   = tree_level + 5'd1;
                  tree_mode    = MODE_NAME;
                  ev.event_res = EV_OPEN;
                end
              end else if (tree_word == TOK_END_NODE) begin
                if (tree_level > 0) tree_level = tree_level - 5'd1;
                if (tree_level == 0) tree_mode = MODE_END_TOKEN;
                ev.event_res = EV_CLOSE;
              end else if (tree_word == TOK_PROP) begin
                tree_mode = MODE_PROP_LEN;
                emit      = 1'b0;
              end else if (tree_word == TOK_NOP) begin
                emit = 1'b0;
              end else begin
                tree_mode    = MODE_ERROR;
                ev.event_res = EV_ERROR;
              end
            end
          endcase
        end
      end
      MODE_NAME: begin
        if (b != 8'd0) begin
          emit         = 1'b1;
          ev.event_res = EV_CHAR;
          ev.name_char = b;
        end else if (done) begin
          tree_mode = MODE_TOKEN;
        end else begin
          tree_mode = MODE_PAD;
        end
      end
      MODE_PAD: begin
        if (done) tree_mode = MODE_TOKEN;
      end
      MODE_PAYLOAD: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) begin
          if (done) tree_mode = MODE_TOKEN;
          else tree_mode = MODE_PAD;
        end
      end
      default: ;
    endcase
    tree_phase = nxt;
    if (emit) begin
      ev.depth = tree_level;
      expected_events.push_back(ev);
    end
    return live;
  endfunction

  // stream building
  function automatic void push_word(input logic [31:0] w);
    block_bytes.push_back(w[31:24]);
    block_bytes.push_back(w[23:16]);
    block_bytes.push_back(w[15:8]);
    block_bytes.push_back(w[7:0]);
  endfunction

  function automatic void pad_to_word();
    while (block_bytes.size() % 4 != 0) block_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_name(input int unsigned len);
    repeat (len) block_bytes.push_back(8'($urandom_range(1, 255)));
    block_bytes.push_back(8'd0);
    pad_to_word();
  endfunction

  function automatic void push_node(input int unsigned name_len);
    push_word(TOK_BEGIN_NODE);
    push_name(name_len);
  endfunction

  function automatic void push_property(input int unsigned len, input logic [31:0] name_off);
    push_word(TOK_PROP);
    push_word(len);
    push_word(name_off);
    repeat (len) block_bytes.push_back(8'($urandom_range(0, 255)));
    pad_to_word();
  endfunction

  function automatic void build_random_tree();
    int unsigned open_nodes;
    int unsigned tokens;
    int unsigned max_nest;
    int unsigned pick;
    block_bytes.delete();
    max_nest = ($urandom_range(0, 9) == 0) ? MaxDepth + 1 : $urandom_range(2, 5);
    push_node($urandom_range(0, 7));
    open_nodes = 1;
    tokens = $urandom_range(3, 14);
    while (open_nodes != 0 && tokens != 0) begin
      tokens--;
      pick = $urandom_range(0, 99);
      if (pick < 30 && open_nodes < max_nest) begin
        push_node($urandom_range(0, 7));
        open_nodes++;
      end else if (pick < 65) begin
        push_property(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 9), $urandom());
      end else if (pick < 72) begin
        push_word(TOK_NOP);
      end else begin
        push_word(TOK_END_NODE);
        open_nodes--;
      end
    end
    repeat (open_nodes) push_word(TOK_END_NODE);
    push_word(TOK_END);
  endfunction

  // driving
  task automatic send_byte(input logic first, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.first_byte <= first;
    in_if.data_byte  <= b;
    do @(posedge clk_i); while (!in_if.ready);
    if (parse_fdt_byte(first, b)) live_bytes++;
    bytes_sent++;
  endtask

  task automatic send_block();
    foreach (block_bytes[i]) send_byte(i == 0, block_bytes[i]);
    blocks_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_events.size() != 0);
  endtask

  // result side: random stalls plus an optional long hold
  always @(posedge clk_i) begin
    if (sink_hold_left != 0) begin
      out_if.ready <= 1'b0;
      sink_hold_left--;
    end else if (sink_stall_left != 0) begin
      out_if.ready <= 1'b0;
      sink_stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 99) < sink_idle_pct)
        sink_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : check_events
    res_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, actual event %0d depth %0d",
                 $time, out_if.event_res, out_if.depth);
        failures++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", want.event_res, out_if.event_res);
        check_field("depth", want.depth, out_if.depth);
        check_field("name_char", want.name_char, out_if.name_char);
        check_field("prop_name_offset", want.prop_name_offset, out_if.prop_name_offset);
        check_field("prop_length", want.prop_length, out_if.prop_length);
        events_checked++;
        event_seen[want.event_res]++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout, %0d events still pending", $time, expected_events.size());
      $display("tb_fdt_structure_block_parser: FAIL");
      $finish;
    end
  end

  // tests
  task automatic test_minimal_block();
    block_bytes.delete();
    push_node(0);
    push_word(TOK_PROP);
    push_word(32'd0);
    push_word(32'hFFFF_FFFF);
    push_word(TOK_NOP);
    push_word(TOK_END_NODE);
    push_word(TOK_END);
    push_word(32'hFFFF_FFFF);  // dropped after finish
    send_block();
  endtask

  task automatic test_first_token();
    block_bytes.delete();
    push_word(TOK_END);
    push_word(TOK_BEGIN_NODE);
    send_block();
    block_bytes.delete();
    push_word(TOK_NOP);
    push_word(TOK_BEGIN_NODE);
    send_block();
    block_bytes.delete();
    push_word(32'hFFFF_FFFF);
    send_block();
  endtask

  task automatic test_name_bytes();
    block_bytes.delete();
    push_word(TOK_BEGIN_NODE);
    block_bytes.push_back(8'h01);
    block_bytes.push_back(8'h7F);
    block_bytes.push_back(8'h80);
    block_bytes.push_back(8'hFF);
    block_bytes.push_back(8'h00);
    pad_to_word();
    // terminator lands on each byte position of a word
    for (int unsigned len = 1; len <= 3; len++) begin
      push_node(len);
      push_word(TOK_END_NODE);
    end
    push_word(TOK_END_NODE);
    push_word(TOK_END);
    send_block();
  endtask

  task automatic test_property_lengths();
    block_bytes.delete();
    push_node(2);
    push_property(5, 32'h8000_0000);
    push_property(4, 32'h0000_0001);
    push_word(TOK_PROP);
    push_word(32'hFFFF_FFFF);
    push_word(32'h7FFF_FFFF);
    repeat (12) block_bytes.push_back(8'($urandom_range(0, 255)));
    send_block();  // next block restarts in the middle of the payload
  endtask

  task automatic test_depth_overflow();
    block_bytes.delete();
    repeat (MaxDepth) push_node(0);
    push_word(TOK_BEGIN_NODE);
    push_word(TOK_END_NODE);
    send_block();
  endtask

  task automatic test_bad_tokens();
    block_bytes.delete();
    push_node(1);
    push_word(32'h8000_0005);
    push_word(TOK_END_NODE);
    send_block();
    block_bytes.delete();
    push_node(0);
    push_word(TOK_END_NODE);
    push_word(TOK_NOP);
    send_block();
    // cut off inside a token word
    block_bytes.delete();
    push_node(0);
    block_bytes.push_back(8'h00);
    block_bytes.push_back(8'h00);
    send_block();
    test_minimal_block();
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_hold_left = 300;
    block_bytes.delete();
    push_node(30);
    push_node(30);
    push_property(3, $urandom());
    push_word(TOK_END_NODE);
    push_node(25);
    push_word(TOK_END_NODE);
    push_word(TOK_END_NODE);
    push_word(TOK_END);
    send_block();
    wait_drained();
  endtask

  task automatic test_random_blocks();
    int unsigned start;
    int unsigned pick;
    start = live_bytes;
    while (live_bytes - start < RandomBytes) begin
      if (live_bytes - start < RandomBytes / 3) begin
        src_idle_pct  = 25;
        sink_idle_pct = 25;
      end else if (live_bytes - start < 2 * RandomBytes / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct  = 50;
        sink_idle_pct = 40;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        block_bytes.delete();
        repeat ($urandom_range(4, 16)) block_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_random_tree();
        if (pick < 20) begin
          block_bytes[$urandom_range(0, block_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick < 30) begin
          pick = $urandom_range(1, block_bytes.size() - 1);
          while (block_bytes.size() > pick) void'(block_bytes.pop_back());
        end else if (pick < 40) begin
          repeat ($urandom_range(1, 8)) block_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
      send_block();
    end
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.first_byte = 1'b0;
    in_if.data_byte  = 8'd0;
    out_if.ready     = 1'b0;
    src_idle_pct     = 20;
    sink_idle_pct    = 20;
    sink_stall_left  = 0;
    sink_hold_left   = 0;
    cycle_count      = 0;
    failures         = 0;
    bytes_sent       = 0;
    live_bytes       = 0;
    blocks_sent      = 0;
    events_checked   = 0;
    foreach (event_seen[i]) event_seen[i] = 0;
    clear_tree_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_minimal_block();
    test_first_token();
    test_name_bytes();
    test_property_lengths();
    test_depth_overflow();
    test_bad_tokens();
    test_backpressure();
    test_random_blocks();

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d bytes (%0d parsed) in %0d structure blocks, %0d events checked",
             bytes_sent, live_bytes, blocks_sent, events_checked);
    $display("events: %0d name chars, %0d opens, %0d closes, %0d props, %0d finishes, %0d errors",
             event_seen[EV_CHAR], event_seen[EV_OPEN], event_seen[EV_CLOSE],
             event_seen[EV_PROP], event_seen[EV_FINISH], event_seen[EV_ERROR]);
    if (failures == 0 && expected_events.size() == 0) begin
      $display("tb_fdt_structure_block_parser: PASS");
    end else begin
      $display("tb_fdt_structure_block_parser: FAIL");
    end
    $finish;
  end

endmodule
